// ----- src/pidfdc_pkg.sv -----
// Shared types, constants and helpers for the filtered-derivative PID block.
// Used by the top level and by the serial multiplier and divider units.
package pidfdc_pkg;

  localparam int CUTOFF_HZ = 20;
  // Filter time constant in Q16.16, rounded: 1/(2*pi*fc).
  localparam int RC_Q16 = (1043037835 + 50000 * CUTOFF_HZ) / (100000 * CUTOFF_HZ);

  localparam int MUL_AW = 35;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 33;
  localparam int ACC_W  = 50;

  typedef enum logic [2:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_SCALE       = 3'd3,
    REG_LIMIT       = 3'd4,
    REG_DERIVE_INT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_AW-1:0]   a;
    logic signed [MUL_BW-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                start;
    logic [DIV_NW-1:0]   num;
    logic [DIV_DW-1:0]   den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > $signed(ACC_W'(64'sd2147483647))) return 32'sh7fffffff;
    if (x < -$signed(ACC_W'(64'sd2147483648))) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// ----- src/pidfdc_mul.sv -----
// Bit-serial signed multiplier: one multiplier bit per cycle, sign applied at the end.
// Depends on pidfdc_pkg for operand widths and the request struct.
module pidfdc_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pidfdc_pkg::mul_req_t                   req,
  output logic                                   done,
  output logic signed [pidfdc_pkg::MUL_PW-1:0]   prod
);
  import pidfdc_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t             state_r;
  logic [5:0]          cnt_r;
  logic [MUL_BW-1:0]   hi_r;
  logic [MUL_AW-1:0]   lo_r;
  logic [MUL_BW-1:0]   bmag_r;
  logic                neg_r;
  logic                done_r;
  logic signed [MUL_PW-1:0] prod_r;

  logic [MUL_AW-1:0]   amag;
  logic [MUL_BW-1:0]   bmag;
  logic [MUL_BW:0]     sum;

  assign amag = req.a[MUL_AW-1] ? MUL_AW'(-req.a) : MUL_AW'(req.a);
  assign bmag = req.b[MUL_BW-1] ? MUL_BW'(-req.b) : MUL_BW'(req.b);
  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, bmag_r} : {(MUL_BW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            hi_r    <= '0;
            lo_r    <= amag;
            bmag_r  <= bmag;
            neg_r   <= req.a[MUL_AW-1] ^ req.b[MUL_BW-1];
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          hi_r  <= sum[MUL_BW:1];
          lo_r  <= {sum[0], lo_r[MUL_AW-1:1]};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(MUL_AW - 1)) state_r <= M_FIN;
        end
        M_FIN: begin
          prod_r  <= neg_r ? -$signed({hi_r, lo_r}) : $signed({hi_r, lo_r});
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ----- src/pidfdc_div.sv -----
// Restoring unsigned divider: one quotient bit per cycle.
// Depends on pidfdc_pkg for operand widths and the request struct.
module pidfdc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pidfdc_pkg::div_req_t              req,
  output logic                              done,
  output logic [pidfdc_pkg::DIV_NW-1:0]     quot
);
  import pidfdc_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t             state_r;
  logic [5:0]          cnt_r;
  logic [DIV_NW-1:0]   num_r;
  logic [DIV_DW-1:0]   den_r;
  logic [DIV_DW-1:0]   rem_r;
  logic                done_r;

  logic [DIV_DW:0]     trial;
  logic [DIV_DW+1:0]   diffw;
  logic                ge;

  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign diffw = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diffw[DIV_DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            num_r   <= req.num;
            den_r   <= req.den;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          // The remainder always stays below the divisor, so it fits its register.
          rem_r <= ge ? diffw[DIV_DW-1:0] : trial[DIV_DW-1:0];
          num_r <= {num_r[DIV_NW-2:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_NW - 1)) state_r <= D_FIN;
        end
        D_FIN: begin
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ----- src/pid_filtered_derivative_clamped.sv -----
// Top level of the PID controller with filtered derivative and clamped integrator.
// Depends on pidfdc_pkg, pidfdc_mul and pidfdc_div.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per control sample:
//   error value, external error rate and elapsed time. The output channel
//   (out_valid/out_ready) returns one drive value beat per input beat, in order.
//   Gains, scaler, integrator limit and derivative mode must be written
//   over the APB-style port only while the block is idle; the block does
//   not enforce this, and pready is always high. Each beat is worked
//   through one shared bit-serial multiplier and one bit-serial divider.
//   One beat is in work at a time, and the block is ready for the next
//   beat in the cycle after the result is loaded.
//   The finished result sits in an output register, so a new beat is accepted
//   while the receiver stalls; that beat waits for the register before leaving.
//   Reset restores the register defaults and clears the previous error, the
//   filtered derivative and the integrator.
module pid_filtered_derivative_clamped (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_error_value,
  input  logic signed [31:0]  in_error_rate,
  input  logic [15:0]         in_elapsed_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_drive_value,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pidfdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MP, S_DRAW, S_ALPHA, S_FILT, S_MD, S_SCALE_GO, S_SCALE,
    S_I1, S_I2, S_I3, S_IADD, S_OUT
  } state_t;

  // Configuration registers.
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, scale_r;
  logic [30:0]        limit_r;
  logic               derive_int_r;

  // Controller state.
  state_t             state_r;
  logic signed [31:0] err_r, rate_r;
  logic [15:0]        dt_r;
  logic signed [31:0] prev_err_r, prev_rate_r, integral_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [33:0] raw_r;
  logic               diff_neg_r;
  logic               out_valid_r;
  logic signed [31:0] out_drive_r;

  mul_req_t           mreq_r;
  div_req_t           dreq_r;
  logic               mul_done, div_done;
  logic signed [MUL_PW-1:0] mul_p;
  logic [DIV_NW-1:0]  div_q;

  pidfdc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq_r), .done(mul_done), .prod(mul_p));
  pidfdc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq_r), .done(div_done), .quot(div_q));

  logic                    cfg_wr;
  logic                    d_en, i_en;
  logic signed [ACC_W-1:0] mul_q;
  logic signed [32:0]      diff;
  logic [32:0]             diff_mag;
  logic signed [33:0]      raw;
  logic signed [34:0]      diff2;
  logic signed [31:0]      filt;
  logic signed [ACC_W-1:0] integ_sum;
  logic signed [ACC_W-1:0] lim;
  logic signed [31:0]      integ_clamped;
  logic                    out_free;
  logic                    mul_start_nxt, div_start_nxt;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      scale_r      <= 32'sd65536;
      limit_r      <= 31'h7fffffff;
      derive_int_r <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_GAIN_P:     gain_p_r     <= pwdata;
        REG_GAIN_I:     gain_i_r     <= pwdata;
        REG_GAIN_D:     gain_d_r     <= pwdata;
        REG_SCALE:      scale_r      <= pwdata;
        REG_LIMIT:      limit_r      <= pwdata[30:0];
        REG_DERIVE_INT: derive_int_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GAIN_P:     prdata = gain_p_r;
      REG_GAIN_I:     prdata = gain_i_r;
      REG_GAIN_D:     prdata = gain_d_r;
      REG_SCALE:      prdata = scale_r;
      REG_LIMIT:      prdata = {1'b0, limit_r};
      REG_DERIVE_INT: prdata = {31'd0, derive_int_r};
      default:        prdata = '0;
    endcase
  end

  assign d_en = (gain_d_r != 32'sd0) && (dt_r != 16'd0);
  assign i_en = (gain_i_r != 32'sd0) && (dt_r != 16'd0);

  // Q16.16 product: an arithmetic shift right by 16 rounds toward minus infinity.
  assign mul_q    = mul_p[ACC_W+15:16];
  assign diff     = $signed({err_r[31], err_r}) - $signed({prev_err_r[31], prev_err_r});
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign raw      = diff_neg_r ? -$signed({1'b0, div_q[32:0]}) : $signed({1'b0, div_q[32:0]});
  assign diff2    = $signed({raw_r[33], raw_r}) - 35'(prev_rate_r);
  assign filt     = sat32(mul_q + ACC_W'(prev_rate_r));
  assign integ_sum = ACC_W'(integral_r) + mul_p[ACC_W-1:0];
  assign lim      = $signed({{(ACC_W-31){1'b0}}, limit_r});
  always_comb begin
    if (integ_sum < -lim)     integ_clamped = 32'(-lim);
    else if (integ_sum > lim) integ_clamped = 32'(lim);
    else                      integ_clamped = integ_sum[31:0];
  end
  assign out_free = ~out_valid_r | out_ready;

  // Start pulses for the shared arithmetic units, one cycle wide.
  always_comb begin
    mul_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    case (state_r)
      S_IDLE:     mul_start_nxt = in_valid;
      S_MP: begin
        mul_start_nxt = mul_done & d_en & ~derive_int_r;
        div_start_nxt = mul_done & d_en & derive_int_r;
      end
      S_DRAW:     div_start_nxt = div_done;
      S_ALPHA:    mul_start_nxt = div_done;
      S_FILT:     mul_start_nxt = mul_done;
      S_SCALE_GO: mul_start_nxt = 1'b1;
      S_SCALE:    mul_start_nxt = mul_done & i_en;
      S_I1, S_I2: mul_start_nxt = mul_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      mreq_r.start <= 1'b0;
      dreq_r.start <= 1'b0;
      prev_err_r   <= '0;
      prev_rate_r  <= '0;
      integral_r   <= '0;
    end else begin
      mreq_r.start <= mul_start_nxt;
      dreq_r.start <= div_start_nxt;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            err_r        <= in_error_value;
            rate_r       <= in_error_rate;
            dt_r         <= in_elapsed_time;
            mreq_r.a     <= 35'(in_error_value);
            mreq_r.b     <= 33'(gain_p_r);
            state_r      <= S_MP;
          end
        end
        S_MP: begin
          if (mul_done) begin
            acc_r <= mul_q;
            if (d_en && derive_int_r) begin
              diff_neg_r   <= diff[32];
              dreq_r.num   <= DIV_NW'(diff_mag);
              dreq_r.den   <= DIV_DW'(dt_r);
              state_r      <= S_DRAW;
            end else if (d_en) begin
              mreq_r.a     <= 35'(gain_d_r);
              mreq_r.b     <= 33'(rate_r);
              state_r      <= S_MD;
            end else begin
              state_r <= S_SCALE_GO;
            end
          end
        end
        S_DRAW: begin
          if (div_done) begin
            raw_r        <= raw;
            dreq_r.num   <= {dt_r, 32'd0};
            dreq_r.den   <= DIV_DW'(RC_Q16) + {1'b0, dt_r, 16'd0};
            state_r      <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          if (div_done) begin
            mreq_r.a     <= diff2;
            mreq_r.b     <= $signed({17'd0, div_q[15:0]});
            state_r      <= S_FILT;
          end
        end
        S_FILT: begin
          if (mul_done) begin
            prev_rate_r  <= filt;
            prev_err_r   <= err_r;
            mreq_r.a     <= 35'(gain_d_r);
            mreq_r.b     <= 33'(filt);
            state_r      <= S_MD;
          end
        end
        S_MD: begin
          if (mul_done) begin
            acc_r   <= acc_r + mul_q;
            state_r <= S_SCALE_GO;
          end
        end
        S_SCALE_GO: begin
          mreq_r.a     <= 35'(sat32(acc_r));
          mreq_r.b     <= 33'(scale_r);
          state_r      <= S_SCALE;
        end
        S_SCALE: begin
          if (mul_done) begin
            acc_r <= mul_q;
            if (i_en) begin
              mreq_r.a     <= 35'(err_r);
              mreq_r.b     <= 33'(gain_i_r);
              state_r      <= S_I1;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_I1: begin
          if (mul_done) begin
            mreq_r.a     <= 35'(sat32(mul_q));
            mreq_r.b     <= 33'(scale_r);
            state_r      <= S_I2;
          end
        end
        S_I2: begin
          if (mul_done) begin
            mreq_r.a     <= 35'(sat32(mul_q));
            mreq_r.b     <= $signed({17'd0, dt_r});
            state_r      <= S_I3;
          end
        end
        S_I3: begin
          if (mul_done) begin
            integral_r <= integ_clamped;
            state_r    <= S_IADD;
          end
        end
        S_IADD: begin
          acc_r   <= acc_r + ACC_W'(integral_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_drive_r <= sat32(acc_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;

endmodule

// ----- src/pidfdc_checker.sv -----
// Port-level checker for the PID controller top level, attached by bind.
// Depends only on the top level's port names.
module pidfdc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_drive_value,
  input logic               pready
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_value))
    else $error("stalled output beat changed or dropped");

  // One beat at a time: the block is busy right after it takes a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A result never appears in the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Loading a result returns the block to accepting input.
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("block not ready after delivering a result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind pid_filtered_derivative_clamped pidfdc_checker u_pidfdc_checker (.*);

// ----- tb/sv/pid_filtered_derivative_clamped_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the filtered-derivative PID block: follows register writes,
// predicts one drive value per accepted input beat and compares output beats.
// Depends on pidfdc_pkg for the register indexes and the filter constant.
module pid_filtered_derivative_clamped_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_error_value,
  input  logic signed [31:0] in_error_rate,
  input  logic [15:0]        in_elapsed_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_drive_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 drives_pending
);
  import pidfdc_pkg::*;

  longint kp, ki, kd, scale, limit;
  bit     use_filter;
  longint last_error, last_rate, integrator;
  logic signed [31:0] drive_fifo[$];

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Q16.16 product, rounded toward minus infinity.
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function logic signed [31:0] next_drive(longint err, longint ext_rate, longint dt);
    longint acc, deriv, raw, alpha, step, sum;
    longint unsigned num, den;
    acc = fx_mul(err, kp);
    if (kd != 0 && dt > 0) begin
      if (use_filter) begin
        raw = (err - last_error) / dt;
        num = longint'(dt) << 32;
        den = longint'(RC_Q16) + (longint'(dt) << 16);
        alpha = longint'(num / den);
        deriv = clip32(last_rate + ((alpha * (raw - last_rate)) >>> 16));
        last_error = err;
        last_rate = deriv;
      end else begin
        deriv = ext_rate;
      end
      acc += fx_mul(kd, deriv);
    end
    acc = fx_mul(clip32(acc), scale);
    if (ki != 0 && dt > 0) begin
      step = clip32(fx_mul(err, ki));
      step = clip32(fx_mul(step, scale));
      sum = integrator + step * dt;
      if (sum < -limit) sum = -limit;
      else if (sum > limit) sum = limit;
      integrator = sum;
      acc += sum;
    end
    return 32'(clip32(acc));
  endfunction

  assign drives_pending = drive_fifo.size();

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst_n) begin
      kp = 0; ki = 0; kd = 0; scale = 65536; limit = 64'h7fffffff;
      use_filter = 1'b1;
      last_error = 0; last_rate = 0; integrator = 0;
      fail_count = 0;
      drive_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_GAIN_P:     kp = longint'($signed(pwdata));
          REG_GAIN_I:     ki = longint'($signed(pwdata));
          REG_GAIN_D:     kd = longint'($signed(pwdata));
          REG_SCALE:      scale = longint'($signed(pwdata));
          REG_LIMIT:      limit = longint'(pwdata[30:0]);
          REG_DERIVE_INT: use_filter = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_fifo.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected drive beat %0d", out_drive_value);
        end else begin
          want = drive_fifo.pop_front();
          if (want !== out_drive_value) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("drive_value mismatch: expected %0d, got %0d", want, out_drive_value);
          end
        end
      end
      if (in_valid && in_ready)
        drive_fifo.push_back(next_drive(longint'(in_error_value),
                                        longint'(in_error_rate),
                                        longint'(in_elapsed_time)));
    end
  end

endmodule

// ----- tb/sv/pid_filtered_derivative_clamped_test.sv -----
`timescale 1ns / 100ps
// Top of the PID block testbench: clock, reset, register writes, sample
// stimulus, output back-pressure and verdict. Depends on pidfdc_pkg, the
// block itself and pid_filtered_derivative_clamped_checker.
module pid_filtered_derivative_clamped_test;
  import pidfdc_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_error_value = '0;
  logic signed [31:0] in_error_rate = '0;
  logic [15:0] in_elapsed_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_drive_value;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int  fail_count, drives_pending, cycle_count = 0;
  bit  send_gaps = 1'b1, recv_gaps = 1'b1, hold_req = 1'b0;
  bit  hold_done = 1'b0;

  pid_filtered_derivative_clamped u_dut (.*);

  pid_filtered_derivative_clamped_checker u_chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pid_filtered_derivative_clamped_test NOT OK");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (1000) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= recv_gaps ? ($urandom_range(99) >= 30) : 1'b1;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (drives_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] s, logic [31:0] lim, logic mode);
    drain();
    reg_write(REG_GAIN_P, p);
    reg_write(REG_GAIN_I, i);
    reg_write(REG_GAIN_D, d);
    reg_write(REG_SCALE, s);
    reg_write(REG_LIMIT, lim);
    reg_write(REG_DERIVE_INT, {31'd0, mode});
  endtask

  task automatic send_sample(logic [31:0] err, logic [31:0] rate, logic [15:0] dt);
    if (send_gaps && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_valid <= 1'b1;
    in_error_value <= err;
    in_error_rate <= rate;
    in_elapsed_time <= dt;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return $urandom();
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    if ($urandom_range(99) < 30) return $urandom();
    return 32'($signed($urandom_range(2000000)) - 1000000);
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hffff;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: internal filtered derivative with integrator and clamp.
    set_gains(32'h10000, 32'h8000, 32'h20000, 32'h10000, 32'h00500000, 1'b1);
    send_sample(32'h7fffffff, 32'h0, 16'd1);
    send_sample(32'h80000000, 32'h0, 16'd1);
    send_sample(32'h80000000, 32'h0, 16'hffff);
    send_sample(32'h00010000, 32'h0, 16'd0);
    send_sample(32'h0, 32'h0, 16'd3);
    send_sample(32'hffffffff, 32'h7fffffff, 16'd7);
    send_sample(32'h7fffffff, 32'h80000000, 16'h8000);
    // External, then internal derivative mode, saturating every stage.
    set_gains(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 1'b0);
    send_sample(32'h7fffffff, 32'h7fffffff, 16'd1);
    send_sample(32'h80000000, 32'h80000000, 16'd2);
    send_sample(32'h12345678, 32'h80000000, 16'd0);
    send_sample(32'h7fffffff, 32'h7fffffff, 16'hffff);
    set_gains(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 1'b1);
    send_sample(32'h7fffffff, 32'h0, 16'd1);
    send_sample(32'h80000000, 32'h7fffffff, 16'd1);
    send_sample(32'h00000001, 32'h0, 16'hffff);

    for (int phase = 0; phase < 8; phase++) begin
      send_gaps = (phase != 3);
      recv_gaps = (phase != 3);
      if (phase == 0)
        set_gains(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 1'b1);
      else if (phase == 1)
        set_gains(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h0, 1'b0);
      else
        set_gains(pick_gain(), pick_gain(), pick_gain(),
                  ($urandom_range(3) == 0) ? pick_gain() : 32'h10000,
                  ($urandom_range(1) == 0) ? $urandom() : 32'($urandom_range(65536 * 50)),
                  1'($urandom_range(1)));
      for (int n = 0; n < 80; n++) begin
        if (phase == 5 && n == 10) hold_req = 1'b1;
        send_sample(pick_error(), $urandom(), pick_dt());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (drives_pending != 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("pid_filtered_derivative_clamped_test OK");
    else
      $display("pid_filtered_derivative_clamped_test NOT OK");
    $finish;
  end

endmodule
